FILE: sv/pps_pkg.sv
// Shared widths, defaults and chain word types for the preemptive priority scheduler.
package pps_pkg;

    localparam int TIME_W        = 16;
    localparam int ID_W          = 4;
    localparam int WORK_W        = 16;
    localparam int PRIO_W        = 8;
    localparam int CFG_W         = 5;
    localparam int DEF_MAX_PROCS = 16;
    localparam int DEF_TIME_BITS = 16;
    localparam logic [CFG_W-1:0] PCOUNT_RESET = 5'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Best-so-far word that walks down the cell row during a scan.
    typedef struct packed {
        logic              go;
        logic              found;
        logic              last;
        logic [PRIO_W-1:0] prio;
    } cand_t;

    // Broadcast update from the controller; a per-cell select picks the target.
    typedef struct packed {
        logic              wr;
        logic              dec;
        logic [WORK_W-1:0] arrival;
        logic [WORK_W-1:0] duration;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

FILE: sv/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: controller, output register and the row of entry cells.
//
//   channel | signals                          | direction | word
//   in      | in_valid / in_stall + fields     | to block  | load or tick item
//   out     | out_valid / out_stall + fields   | from block| one result per item
//   cfg     | cfg_valid / cfg_ready, cfg_data  | to block  | process_count
//
// A tick passes the best-candidate word down the row one cell per cycle; once it leaves
// the row the block moves to the commit state, then back to idle. A load goes to the
// commit state and then back to idle, with no scan. Reset clears time, the
// running segment, the finished count and sets process_count to 1; entry contents are
// undefined until loaded. A stalled output holds the finished word while the block still
// accepts the next item, whose result then waits in the commit state.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_PROCS = DEF_MAX_PROCS,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [ID_W-1:0]   proc_id,
    input  logic [WORK_W-1:0] arrival,
    input  logic [WORK_W-1:0] duration,
    input  logic [PRIO_W-1:0] priority_req,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TIME_W-1:0] time_now,
    output logic [ID_W-1:0]   running_id,
    output logic              idle,
    output logic              preempt_valid,
    output logic [ID_W-1:0]   preempt_id,
    output logic [TIME_W-1:0] preempt_start,
    output logic              done_valid,
    output logic [ID_W-1:0]   done_id,
    output logic [TIME_W-1:0] done_start,
    output logic [TIME_W-1:0] exit_time,
    output logic              all_done,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int IW  = $clog2(MAX_PROCS);
    localparam int FW  = $clog2(MAX_PROCS + 1);
    localparam int WB  = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
    localparam int IWB = (IW > ID_W) ? IW : ID_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } state_t;

    function automatic logic [TIME_W-1:0] to_port_time(input logic [TIME_BITS-1:0] t);
        logic [WB-1:0] w;
        w = WB'(t);
        return w[TIME_W-1:0];
    endfunction

    function automatic logic [ID_W-1:0] to_port_id(input logic [IW-1:0] i);
        logic [IWB-1:0] w;
        w = IWB'(i);
        return w[ID_W-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    state_t               state_reg, state_next;
    logic                 start_reg, start_next;
    logic [CFG_W-1:0]     pcount_reg;

    logic                 kind_reg;
    logic [ID_W-1:0]      id_reg;
    logic [WORK_W-1:0]    arr_reg;
    logic [WORK_W-1:0]    dur_reg;
    logic [PRIO_W-1:0]    prio_reg;

    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [IW-1:0]        cur_id_reg, cur_id_next;
    logic [TIME_BITS-1:0] seg_reg, seg_next;
    logic [FW-1:0]        fin_reg, fin_next;

    logic                 out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]    time_now_reg, time_now_next;
    logic [ID_W-1:0]      running_id_reg, running_id_next;
    logic                 idle_reg, idle_next;
    logic                 pre_valid_reg, pre_valid_next;
    logic [ID_W-1:0]      pre_id_reg, pre_id_next;
    logic [TIME_W-1:0]    pre_start_reg, pre_start_next;
    logic                 done_valid_reg, done_valid_next;
    logic [ID_W-1:0]      done_id_reg, done_id_next;
    logic [TIME_W-1:0]    done_start_reg, done_start_next;
    logic [TIME_W-1:0]    exit_reg, exit_next;
    logic                 all_done_reg, all_done_next;

    cand_t                chain [MAX_PROCS+1];
    logic [IW-1:0]        idx_chain [MAX_PROCS+1];
    cand_t                best;
    logic [IW-1:0]        best_idx;
    cmd_t                 cmd;
    logic [MAX_PROCS-1:0] sel;

    logic                 accept;
    logic                 commit;
    logic                 switch_proc;
    int                   counted;

    assign accept    = in_valid && !in_stall;
    assign commit    = (state_reg == S_WRITE) && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign best      = chain[MAX_PROCS];
    assign best_idx  = idx_chain[MAX_PROCS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= PCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pcount_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            id_reg   <= proc_id;
            arr_reg  <= arrival;
            dur_reg  <= duration;
            prio_reg <= priority_req;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_TICK)
                    begin
                        start_next = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_SCAN:
            begin
                if (best.go)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commit: update the schedule and build the result word.
    always_comb
    begin
        counted = (int'(pcount_reg) > MAX_PROCS) ? MAX_PROCS : int'(pcount_reg);

        tick_next      = tick_reg;
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        seg_next       = seg_reg;
        fin_next       = fin_reg;
        switch_proc    = 1'b0;

        cmd.wr       = 1'b0;
        cmd.dec      = 1'b0;
        cmd.arrival  = arr_reg;
        cmd.duration = dur_reg;
        cmd.prio     = prio_reg;

        time_now_next   = to_port_time(tick_reg);
        running_id_next = '0;
        idle_next       = 1'b1;
        pre_valid_next  = 1'b0;
        pre_id_next     = '0;
        pre_start_next  = '0;
        done_valid_next = 1'b0;
        done_id_next    = '0;
        done_start_next = '0;
        exit_next       = '0;

        if (commit)
        begin
            if (kind_reg == KIND_LOAD)
            begin
                cmd.wr         = 1'b1;
                tick_next      = '0;
                cur_valid_next = 1'b0;
                cur_id_next    = '0;
                seg_next       = '0;
                fin_next       = '0;
            end
            else
            begin
                if (best.found)
                begin
                    idle_next   = 1'b0;
                    switch_proc = !cur_valid_reg || (cur_id_reg != best_idx);
                    if (switch_proc)
                    begin
                        seg_next = tick_reg;
                        if (cur_valid_reg)
                        begin
                            pre_valid_next = 1'b1;
                            pre_id_next    = to_port_id(cur_id_reg);
                            pre_start_next = to_port_time(seg_reg);
                        end
                    end
                    running_id_next = to_port_id(best_idx);
                    cmd.dec         = 1'b1;
                    if (best.last)
                    begin
                        done_valid_next = 1'b1;
                        done_id_next    = to_port_id(best_idx);
                        done_start_next = to_port_time(seg_next);
                        exit_next       = to_port_time(sat_inc(tick_reg));
                        fin_next        = (fin_reg == '1) ? fin_reg : fin_reg + 1'b1;
                        cur_valid_next  = 1'b0;
                        cur_id_next     = '0;
                    end
                    else
                    begin
                        cur_valid_next = 1'b1;
                        cur_id_next    = best_idx;
                    end
                end
                tick_next = sat_inc(tick_reg);
            end
        end

        all_done_next = int'(fin_next) >= counted;

        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            tick_reg      <= '0;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            seg_reg       <= '0;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            tick_reg      <= tick_next;
            cur_valid_reg <= cur_valid_next;
            cur_id_reg    <= cur_id_next;
            seg_reg       <= seg_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            time_now_reg   <= time_now_next;
            running_id_reg <= running_id_next;
            idle_reg       <= idle_next;
            pre_valid_reg  <= pre_valid_next;
            pre_id_reg     <= pre_id_next;
            pre_start_reg  <= pre_start_next;
            done_valid_reg <= done_valid_next;
            done_id_reg    <= done_id_next;
            done_start_reg <= done_start_next;
            exit_reg       <= exit_next;
            all_done_reg   <= all_done_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign time_now      = time_now_reg;
    assign running_id    = running_id_reg;
    assign idle          = idle_reg;
    assign preempt_valid = pre_valid_reg;
    assign preempt_id    = pre_id_reg;
    assign preempt_start = pre_start_reg;
    assign done_valid    = done_valid_reg;
    assign done_id       = done_id_reg;
    assign done_start    = done_start_reg;
    assign exit_time     = exit_reg;
    assign all_done      = all_done_reg;

    // Seed the scan with an empty candidate.
    assign chain[0].go    = start_reg;
    assign chain[0].found = 1'b0;
    assign chain[0].last  = 1'b0;
    assign chain[0].prio  = '0;
    assign idx_chain[0]   = '0;

    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        assign sel[i] = cmd.wr ? (int'(id_reg) == i) : (int'(best_idx) == i);

        pps_cell #(
            .IDX       (i),
            .MAX_PROCS (MAX_PROCS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cand_in  (chain[i]),
            .idx_in   (idx_chain[i]),
            .cand_out (chain[i+1]),
            .idx_out  (idx_chain[i+1]),
            .cmd      (cmd),
            .sel      (sel[i]),
            .tick     (tick_reg),
            .pcount   (pcount_reg)
        );
    end

`ifndef NO_ASSERTIONS
    a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        best.go |-> state_reg == S_SCAN)
        else $error("scan word left the row outside the scan state");

    a_idle_no_segments: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && idle) |-> (!preempt_valid && !done_valid))
        else $error("idle result reports a segment");

    a_done_is_runner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_valid) |-> (running_id == done_id))
        else $error("finished entry differs from running entry");

    a_finish_clears_cur: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && kind_reg == KIND_TICK && best.found && best.last) |=> !cur_valid_reg)
        else $error("running segment kept after finish");
`endif

endmodule

FILE: sv/pps_cell.sv
// One process entry of the scheduler row, with its stage of the priority scan.
module pps_cell
    import pps_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int MAX_PROCS = DEF_MAX_PROCS,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cand_t                        cand_in,
    input  logic [$clog2(MAX_PROCS)-1:0] idx_in,
    output cand_t                        cand_out,
    output logic [$clog2(MAX_PROCS)-1:0] idx_out,
    input  cmd_t                         cmd,
    input  logic                         sel,
    input  logic [TIME_BITS-1:0]         tick,
    input  logic [CFG_W-1:0]             pcount
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int WB = (TIME_BITS > WORK_W) ? TIME_BITS : WORK_W;

    logic [WORK_W-1:0] arrival_reg;
    logic [WORK_W-1:0] remain_reg;
    logic [PRIO_W-1:0] prio_reg;

    logic              go_reg;
    logic              found_reg;
    logic              last_reg;
    logic [PRIO_W-1:0] scan_prio_reg;
    cand_t             cand_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;

    logic [WB-1:0]     arr_ext;
    logic [WB-1:0]     tick_ext;
    logic              enabled;
    logic              ready;
    logic              take;

    always_ff @(posedge clk)
    begin
        if (cmd.wr && sel)
        begin
            arrival_reg <= cmd.arrival;
            remain_reg  <= cmd.duration;
            prio_reg    <= cmd.prio;
        end
        else if (cmd.dec && sel)
        begin
            remain_reg <= remain_reg - 1'b1;
        end
    end

    always_comb
    begin
        arr_ext   = WB'(arrival_reg);
        tick_ext  = WB'(tick);
        enabled   = IDX < int'(pcount);
        ready     = (remain_reg != '0) && (arr_ext <= tick_ext);
        take      = enabled && ready && (!cand_in.found || (prio_reg > cand_in.prio));
        cand_next = cand_in;
        idx_next  = idx_in;
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.last  = (remain_reg == WORK_W'(1));
            cand_next.prio  = prio_reg;
            idx_next        = IW'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= cand_in.go;
        end
    end

    // Hold the payload between scans so the row end stays readable.
    always_ff @(posedge clk)
    begin
        if (cand_in.go)
        begin
            found_reg     <= cand_next.found;
            last_reg      <= cand_next.last;
            scan_prio_reg <= cand_next.prio;
            idx_reg       <= idx_next;
        end
    end

    always_comb
    begin
        cand_out.go    = go_reg;
        cand_out.found = found_reg;
        cand_out.last  = last_reg;
        cand_out.prio  = scan_prio_reg;
    end

    assign idx_out = idx_reg;

endmodule
